[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL. All sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent at the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/rid_pkg.sv]
// ----------------------------------------------------------------------------
// rid_pkg
// Field widths, operation and status codes, and control state encoding.
// ----------------------------------------------------------------------------
package rid_pkg;

  localparam int KIND_W = 4;
  localparam int POS_W  = 10;
  localparam int DATA_W = 64;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 11;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_LEFT  = 4'd0,
    K_PUSH_RIGHT = 4'd1,
    K_POP_LEFT   = 4'd2,
    K_POP_RIGHT  = 4'd3,
    K_PEEK_LEFT  = 4'd4,
    K_PEEK_RIGHT = 4'd5,
    K_GET        = 4'd6,
    K_SET        = 4'd7,
    K_REVERSE    = 4'd8
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    S_OK    = 2'd0,
    S_EMPTY = 2'd1,
    S_FULL  = 2'd2,
    S_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

[rtl/rid_ram.sv]
// ----------------------------------------------------------------------------
// rid_ram
// Generic single-port synchronous RAM, registered read, no reset.
// ----------------------------------------------------------------------------
module rid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/reversible_indexed_deque.sv]
// ----------------------------------------------------------------------------
// reversible_indexed_deque
// Bounded deque of signed 64-bit values in a circular buffer, with indexed
// access and constant-time reverse.
// ----------------------------------------------------------------------------
// One operation is taken per beat and gives exactly one result beat holding
// the read value, a status and the occupancy after the operation. Values live
// in a single-port RAM of CAPACITY entries; the front pointer, the count and
// the reversed flag live in flops, so reverse only flips a bit. Push, pop,
// set, reverse, unused kinds and every error case load their result into
// the output register at the accept edge; a successful peek or get first
// registers the RAM read data, then posts it from ST_READ. One operation
// is in flight at a time. A new beat is taken while the previous result is
// being handed off, so a free-flowing output sustains 1 item per cycle
// for non-reading operations. RAM contents are undefined after reset and no
// clearing pass is run: a read can only reach an entry written earlier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reversible_indexed_deque #(
  parameter int CAPACITY = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // operation channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rid_pkg::KIND_W-1:0]       in_kind,
  input  logic [rid_pkg::POS_W-1:0]        in_position,
  input  logic signed [rid_pkg::DATA_W-1:0] in_item_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rid_pkg::DATA_W-1:0] out_read_value,
  output logic [rid_pkg::STAT_W-1:0]       out_status,
  output logic [rid_pkg::OCC_W-1:0]        out_occupancy
);

  // address, count and compare widths
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = AW + 1;
  localparam int CMPW = (CW > rid_pkg::POS_W) ? CW : rid_pkg::POS_W;
  localparam int OXW  = CW + rid_pkg::OCC_W;

  // ring add: both operands below CAPACITY, so one subtract wraps the sum
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
    logic [SW-1:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // occupancy is reported modulo 2^11
  function automatic logic [rid_pkg::OCC_W-1:0] occ_of(input logic [CW-1:0] c);
    logic [OXW-1:0] t;
    t = OXW'(c);
    return t[rid_pkg::OCC_W-1:0];
  endfunction

  // state
  rid_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   fp_r, fp_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            rev_r, rev_nxt;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [rid_pkg::DATA_W-1:0] rd_r, rd_nxt;
  logic [rid_pkg::STAT_W-1:0]        stat_r, stat_nxt;
  logic [rid_pkg::OCC_W-1:0]         occ_r, occ_nxt;

  // RAM port
  logic                      mem_en, mem_we;
  logic [AW-1:0]             mem_addr;
  logic [rid_pkg::DATA_W-1:0] mem_rdata;

  // decode
  rid_pkg::kind_t kind;
  logic           in_fire;
  logic           full, empty, range_bad;
  logic [CMPW-1:0] pos_ext, cnt_ext, lidx, off;
  logic [AW-1:0]  idx_addr, fp_dec, fp_inc, tail_addr;
  logic           left_op, phys_left;

  assign kind    = rid_pkg::kind_t'(in_kind);
  assign in_stall = !((state_r == rid_pkg::ST_IDLE) && (!out_valid_r || !out_stall));
  assign in_fire = in_valid && !in_stall;

  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_ext   = CMPW'(in_position);
  assign cnt_ext   = CMPW'(count_r);
  assign range_bad = (pos_ext >= cnt_ext);

  // logical index -> offset from the physical front
  always_comb begin
    case (kind)
      rid_pkg::K_PEEK_LEFT:  lidx = '0;
      rid_pkg::K_PEEK_RIGHT: lidx = cnt_ext - CMPW'(1);
      default:               lidx = pos_ext;
    endcase
  end
  assign off      = rev_r ? (cnt_ext - CMPW'(1) - lidx) : lidx;
  assign idx_addr = ring_add(fp_r, off[AW-1:0]);

  assign fp_dec    = (fp_r == '0) ? AW'(CAPACITY - 1) : (fp_r - AW'(1));
  assign fp_inc    = ring_add(fp_r, AW'(1));
  assign tail_addr = ring_add(fp_r, count_r[AW-1:0]);

  // left ops hit the physical left unless reversed
  assign left_op   = (kind == rid_pkg::K_PUSH_LEFT) || (kind == rid_pkg::K_POP_LEFT);
  assign phys_left = left_op ? !rev_r : rev_r;

  always_comb begin
    state_nxt     = state_r;
    fp_nxt        = fp_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = idx_addr;
    out_valid_nxt = out_valid_r && out_stall;
    rd_nxt        = rd_r;
    stat_nxt      = stat_r;
    occ_nxt       = occ_r;

    case (state_r)
      rid_pkg::ST_IDLE: begin
        if (in_fire) begin
          stat_nxt = rid_pkg::S_OK;
          case (kind)
            rid_pkg::K_PUSH_LEFT, rid_pkg::K_PUSH_RIGHT: begin
              if (full) begin
                stat_nxt = rid_pkg::S_FULL;
              end else begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = phys_left ? fp_dec : tail_addr;
                fp_nxt    = phys_left ? fp_dec : fp_r;
                count_nxt = count_r + CW'(1);
              end
            end
            rid_pkg::K_POP_LEFT, rid_pkg::K_POP_RIGHT: begin
              if (empty) begin
                stat_nxt = rid_pkg::S_EMPTY;
              end else begin
                fp_nxt    = phys_left ? fp_inc : fp_r;
                count_nxt = count_r - CW'(1);
              end
            end
            rid_pkg::K_PEEK_LEFT, rid_pkg::K_PEEK_RIGHT: begin
              if (empty) begin
                stat_nxt = rid_pkg::S_EMPTY;
              end else begin
                mem_en    = 1'b1;
                state_nxt = rid_pkg::ST_READ;
              end
            end
            rid_pkg::K_GET: begin
              if (range_bad) begin
                stat_nxt = rid_pkg::S_RANGE;
              end else begin
                mem_en    = 1'b1;
                state_nxt = rid_pkg::ST_READ;
              end
            end
            rid_pkg::K_SET: begin
              if (range_bad) begin
                stat_nxt = rid_pkg::S_RANGE;
              end else begin
                mem_en = 1'b1;
                mem_we = 1'b1;
              end
            end
            rid_pkg::K_REVERSE: begin
              rev_nxt = !rev_r;
            end
            default: begin
            end
          endcase
          // non-reading ops post their result right away
          if (state_nxt == rid_pkg::ST_IDLE) begin
            out_valid_nxt = 1'b1;
            rd_nxt        = '0;
            occ_nxt       = occ_of(count_nxt);
          end
        end
      end
      rid_pkg::ST_READ: begin
        // output slot is free here: it was empty or drained at the accept edge
        out_valid_nxt = 1'b1;
        rd_nxt        = $signed(mem_rdata);
        stat_nxt      = rid_pkg::S_OK;
        occ_nxt       = occ_of(count_r);
        state_nxt     = rid_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rid_pkg::ST_IDLE;
      fp_r        <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    stat_r <= stat_nxt;
    occ_r  <= occ_nxt;
  end

  rid_ram #(
    .WIDTH (rid_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ($unsigned(in_item_value)),
    .rdata (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = rd_r;
  assign out_status     = stat_r;
  assign out_occupancy  = occ_r;

  // checks
  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "count above capacity")
  `ASSERT_ALWAYS(a_fp_bound, fp_r <= AW'(CAPACITY - 1), "front pointer out of ring")
  `ASSERT_IMPL(a_read_slot_free, state_r == rid_pkg::ST_READ, !out_valid_r,
               "read pending while result slot occupied")
  `ASSERT_NEXT(a_pop_dec, in_fire && !empty && ((kind == rid_pkg::K_POP_LEFT) ||
               (kind == rid_pkg::K_POP_RIGHT)), count_r == $past(count_r) - CW'(1),
               "pop did not shrink count")
  `ASSERT_NEXT(a_read_done, state_r == rid_pkg::ST_READ,
               out_valid_r && (state_r == rid_pkg::ST_IDLE), "read result not posted")

endmodule
